@@ hdl/keypad_event_queue_defines.svh @@
// Assertion macros shared by the keypad event queue modules.
`ifndef KEYPAD_EVENT_QUEUE_DEFINES_SVH
`define KEYPAD_EVENT_QUEUE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define KEQ_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define KEQ_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/keq_pkg.sv @@
// Package with constants, types and helpers of the keypad event queue.
`default_nettype none

package keq_pkg;

  localparam int QUEUE_DEPTH = 256;
  localparam int NUM_KEYS    = 6;
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);

  localparam int KIND_W      = 3;
  localparam int KEY_W       = 3;
  localparam int STATUS_W    = 2;
  localparam int WINDOW_W    = 16;
  localparam int HOLD_W      = 10;
  localparam int TIME_W      = 32;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;

  localparam int OUTQ_DEPTH  = 4;
  localparam int OQ_PTR_W    = $clog2(OUTQ_DEPTH);
  localparam int OQ_CNT_W    = $clog2(OUTQ_DEPTH + 2);

  localparam logic [WINDOW_W-1:0] WINDOW_RESET = WINDOW_W'(30);
  localparam logic [HOLD_W-1:0]   HOLD_RESET   = HOLD_W'(250);

  typedef enum logic [KIND_W-1:0] {
    KIND_TICK  = 3'd0,
    KIND_PRESS = 3'd1,
    KIND_READ  = 3'd2,
    KIND_CLEAR = 3'd3,
    KIND_FLAG  = 3'd4
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE     = 2'd0,
    ST_KEY      = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_DISABLED = 2'd3
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KEYS_ENABLED  = 2'd0,
    CFG_REPEAT_WINDOW = 2'd1,
    CFG_HOLD_TICKS    = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [KEY_W-1:0]  key_index;
    logic              power_level;
  } item_t;

  typedef struct packed {
    logic             we;
    logic [PTR_W-1:0] waddr;
    logic [KEY_W-1:0] wdata;
    logic             re;
    logic [PTR_W-1:0] raddr;
  } store_req_t;

  typedef struct packed {
    logic    valid;
    status_e status;
    logic    power_off;
    logic    is_read;
  } stage_t;

  typedef struct packed {
    status_e          status;
    logic [KEY_W-1:0] key_out;
    logic             power_off;
  } result_t;

  function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

endpackage

`default_nettype wire

@@ hdl/keq_in_if.sv @@
// Input item channel of the keypad event queue.
`default_nettype none

interface keq_in_if;
  logic                        valid;
  logic                        ready;
  logic [keq_pkg::KIND_W-1:0]  kind;
  logic [keq_pkg::KEY_W-1:0]   key_index;
  logic                        power_level;

  modport source (output valid, kind, key_index, power_level, input ready);
  modport sink   (input valid, kind, key_index, power_level, output ready);
endinterface

`default_nettype wire

@@ hdl/keq_out_if.sv @@
// Result channel of the keypad event queue.
`default_nettype none

interface keq_out_if;
  logic                         valid;
  logic                         ready;
  logic [keq_pkg::STATUS_W-1:0] status;
  logic [keq_pkg::KEY_W-1:0]    key_out;
  logic                         power_off;

  modport source (output valid, status, key_out, power_off, input ready);
  modport sink   (input valid, status, key_out, power_off, output ready);
endinterface

`default_nettype wire

@@ hdl/keq_cfg_if.sv @@
// Configuration write channel of the keypad event queue.
`default_nettype none

interface keq_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [keq_pkg::CFG_IDX_W-1:0]  index;
  logic [keq_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ hdl/keq_store.sv @@
// Key ring buffer memory with one write port and one registered read port.
`default_nettype none

module keq_store (
  input  wire logic                        clk_i,
  input  wire keq_pkg::store_req_t         req_i,
  output logic [keq_pkg::KEY_W-1:0]        rd_data_o
);

  logic [keq_pkg::KEY_W-1:0] mem [keq_pkg::QUEUE_DEPTH];
  logic [keq_pkg::KEY_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rd_data_q <= mem[req_i.raddr];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

@@ hdl/keq_ctrl.sv @@
// Item processing: configuration, pointers, repeat filter and power hold.
`default_nettype none
`include "keypad_event_queue_defines.svh"

module keq_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  keq_cfg_if.sink                  cfg_i,
  input  wire logic                fire_i,
  input  wire keq_pkg::item_t      item_i,
  output keq_pkg::store_req_t      store_req_o,
  output keq_pkg::stage_t          stage_o
);

  logic                          en_q, en_d;
  logic [keq_pkg::WINDOW_W-1:0]  window_q, window_d;
  logic [keq_pkg::HOLD_W-1:0]    hold_ticks_q, hold_ticks_d;
  logic [keq_pkg::PTR_W-1:0]     wp_q, wp_d, rp_q, rp_d;
  logic [keq_pkg::KEY_W-1:0]     lk_q, lk_d;
  logic                          lkv_q, lkv_d;
  logic [keq_pkg::TIME_W-1:0]    lkt_q, lkt_d, tick_q, tick_d;
  logic [keq_pkg::HOLD_W-1:0]    hold_q, hold_d;
  logic                          latch_q, latch_d;
  keq_pkg::stage_t               stage_q, stage_d;
  keq_pkg::store_req_t           req;

  logic [keq_pkg::HOLD_W-1:0]    need, hold_inc;
  logic [keq_pkg::TIME_W-1:0]    age;
  logic [keq_pkg::PTR_W-1:0]     wp_next;
  logic                          repeat_hit, key_ok;

  assign cfg_i.ready = 1'b1;

  assign need       = (hold_ticks_q == '0) ? keq_pkg::HOLD_W'(1) : hold_ticks_q;
  assign hold_inc   = hold_q + 1'b1;
  assign age        = tick_q - lkt_q;
  assign wp_next    = keq_pkg::ptr_next(wp_q);
  assign key_ok     = 32'(item_i.key_index) < 32'(keq_pkg::NUM_KEYS);
  assign repeat_hit = lkv_q && (item_i.key_index == lk_q) &&
                      (age < {{(keq_pkg::TIME_W - keq_pkg::WINDOW_W){1'b0}}, window_q});

  always_comb begin
    en_d         = en_q;
    window_d     = window_q;
    hold_ticks_d = hold_ticks_q;
    wp_d         = wp_q;
    rp_d         = rp_q;
    lk_d         = lk_q;
    lkv_d        = lkv_q;
    lkt_d        = lkt_q;
    tick_d       = tick_q;
    hold_d       = hold_q;
    latch_d      = latch_q;
    req          = '0;
    req.waddr    = wp_q;
    req.wdata    = item_i.key_index;
    req.raddr    = rp_q;
    stage_d      = '0;
    stage_d.status = keq_pkg::ST_DONE;

    if (fire_i) begin
      stage_d.valid = 1'b1;
      unique case (keq_pkg::kind_e'(item_i.kind))
        keq_pkg::KIND_TICK: begin
          tick_d = tick_q + 1'b1;
          if (!en_q || latch_q || !item_i.power_level) begin
            hold_d = '0;
          end else if (hold_inc >= need) begin
            latch_d = 1'b1;
            hold_d  = '0;
          end else begin
            hold_d = hold_inc;
          end
        end
        keq_pkg::KIND_PRESS: begin
          if (en_q && key_ok && !repeat_hit) begin
            req.we = 1'b1;
            wp_d   = wp_next;
            if (wp_next == rp_q) begin
              rp_d = keq_pkg::ptr_next(rp_q);
            end
            lk_d  = item_i.key_index;
            lkv_d = 1'b1;
            lkt_d = tick_q;
          end
        end
        keq_pkg::KIND_READ: begin
          if (!en_q) begin
            stage_d.status = keq_pkg::ST_DISABLED;
          end else if (rp_q == wp_q) begin
            stage_d.status = keq_pkg::ST_EMPTY;
          end else begin
            stage_d.status  = keq_pkg::ST_KEY;
            stage_d.is_read = 1'b1;
            req.re          = 1'b1;
            rp_d            = keq_pkg::ptr_next(rp_q);
          end
        end
        keq_pkg::KIND_CLEAR: begin
          rp_d = '0;
          wp_d = '0;
        end
        keq_pkg::KIND_FLAG: begin
          if (!en_q) begin
            stage_d.status = keq_pkg::ST_DISABLED;
          end else begin
            stage_d.power_off = latch_q;
            latch_d           = 1'b0;
          end
        end
        default: begin
        end
      endcase
    end

    if (cfg_i.valid) begin
      unique case (keq_pkg::cfg_idx_e'(cfg_i.index))
        keq_pkg::CFG_KEYS_ENABLED:  en_d         = cfg_i.data[0];
        keq_pkg::CFG_REPEAT_WINDOW: window_d     = cfg_i.data[keq_pkg::WINDOW_W-1:0];
        keq_pkg::CFG_HOLD_TICKS:    hold_ticks_d = cfg_i.data[keq_pkg::HOLD_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q         <= 1'b1;
      window_q     <= keq_pkg::WINDOW_RESET;
      hold_ticks_q <= keq_pkg::HOLD_RESET;
      wp_q         <= '0;
      rp_q         <= '0;
      lk_q         <= '0;
      lkv_q        <= 1'b0;
      lkt_q        <= '0;
      tick_q       <= '0;
      hold_q       <= '0;
      latch_q      <= 1'b0;
      stage_q      <= '0;
    end else begin
      en_q         <= en_d;
      window_q     <= window_d;
      hold_ticks_q <= hold_ticks_d;
      wp_q         <= wp_d;
      rp_q         <= rp_d;
      lk_q         <= lk_d;
      lkv_q        <= lkv_d;
      lkt_q        <= lkt_d;
      tick_q       <= tick_d;
      hold_q       <= hold_d;
      latch_q      <= latch_d;
      stage_q      <= stage_d;
    end
  end

  assign store_req_o = req;
  assign stage_o     = stage_q;

  `KEQ_ASSERT_IMPL(a_read_not_empty, clk_i, rst_ni,
                   req.re, rp_q != wp_q,
                   "read from empty ring")
  `KEQ_ASSERT_NEXT(a_flag_clears, clk_i, rst_ni,
                   fire_i && en_q && item_i.kind == keq_pkg::KIND_FLAG, !latch_q,
                   "latch not cleared by flag fetch")
  `KEQ_ASSERT_IMPL(a_latch_hold_zero, clk_i, rst_ni,
                   latch_q, hold_q == '0,
                   "hold count runs while latched")

endmodule

`default_nettype wire

@@ hdl/keq_outq.sv @@
// Result queue that decouples item processing from the result channel.
`default_nettype none
`include "keypad_event_queue_defines.svh"

module keq_outq (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire keq_pkg::stage_t            stage_i,
  input  wire logic [keq_pkg::KEY_W-1:0]  rd_data_i,
  output logic                            space_o,
  keq_out_if.source                       res_o
);

  keq_pkg::result_t                 entries [keq_pkg::OUTQ_DEPTH];
  keq_pkg::result_t                 head, incoming;
  logic [keq_pkg::OQ_PTR_W-1:0]     wr_ptr_q, rd_ptr_q;
  logic [keq_pkg::OQ_CNT_W-1:0]     cnt_q, cnt_d;
  logic                             push, pop;

  assign push = stage_i.valid;
  assign pop  = res_o.valid && res_o.ready;

  // The read data register holds the popped key in the cycle after the read.
  always_comb begin
    incoming.status    = stage_i.status;
    incoming.key_out   = stage_i.is_read ? rd_data_i : '0;
    incoming.power_off = stage_i.power_off;
  end

  always_comb begin
    cnt_d = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push && pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  // Room for the item in flight plus a new one.
  assign space_o = (cnt_q + keq_pkg::OQ_CNT_W'(stage_i.valid)) <
                   keq_pkg::OQ_CNT_W'(keq_pkg::OUTQ_DEPTH);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entries[wr_ptr_q] <= incoming;
    end
  end

  assign head            = entries[rd_ptr_q];
  assign res_o.valid     = cnt_q != '0;
  assign res_o.status    = head.status;
  assign res_o.key_out   = head.key_out;
  assign res_o.power_off = head.power_off;

  `KEQ_ASSERT_IMPL(a_no_overflow, clk_i, rst_ni,
                   push, cnt_q != keq_pkg::OQ_CNT_W'(keq_pkg::OUTQ_DEPTH) || pop,
                   "push into full result queue")
  `KEQ_ASSERT_NEXT(a_count_up, clk_i, rst_ni,
                   push && !pop, cnt_q == $past(cnt_q) + 1'b1,
                   "result count did not grow")

endmodule

`default_nettype wire

@@ hdl/keypad_event_queue.sv @@
// Top level of the keypad event queue.
`default_nettype none

// Keypad event queue: items of five kinds (tick, key press, read key, clear
// queue, take power flag) arrive on the input channel and each one yields
// exactly one result beat. A new item can be taken in every cycle; each
// item's state update is done in the cycle it is accepted, and its result
// goes through the stage register and a four-entry result queue to the result
// channel. The queue decouples the result side, so input beats keep flowing
// while results wait, and the input stalls only once that queue and the item in
// flight fill it. The key ring buffer is a single-port-write, registered-read
// memory of QUEUE_DEPTH entries that holds up to QUEUE_DEPTH - 1 keys; when
// it is full, a new key drops the oldest one. The memory has no reset and no
// clearing pass, since only written entries are ever read. Configuration
// writes are always taken and should be issued only while the block is idle.
module keypad_event_queue (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  keq_cfg_if.sink    cfg_i,
  keq_in_if.sink     evt_i,
  keq_out_if.source  res_o
);

  keq_pkg::item_t               item;
  keq_pkg::store_req_t          store_req;
  keq_pkg::stage_t              stage;
  logic [keq_pkg::KEY_W-1:0]    rd_data;
  logic                         space;
  logic                         fire;

  assign evt_i.ready = space;
  assign fire        = evt_i.valid && evt_i.ready;

  assign item.kind        = evt_i.kind;
  assign item.key_index   = evt_i.key_index;
  assign item.power_level = evt_i.power_level;

  // All item decoding and state updates, plus the configuration registers.
  keq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_i),
    .fire_i      (fire),
    .item_i      (item),
    .store_req_o (store_req),
    .stage_o     (stage)
  );

  // Key ring buffer storage.
  keq_store u_store (
    .clk_i     (clk_i),
    .req_i     (store_req),
    .rd_data_o (rd_data)
  );

  // Result queue; it merges the popped key from the memory read register.
  keq_outq u_outq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .stage_i   (stage),
    .rd_data_i (rd_data),
    .space_o   (space),
    .res_o     (res_o)
  );

endmodule

`default_nettype wire
